[rtl/core/ddtm_pkg.sv]
// ddtm_pkg: types, codes and constants for the differential drive teleop mixer
// no dependencies; used by the result interface, the mixer logic, the top level and the checker
package ddtm_pkg;

    localparam int unsigned PwmW    = 11;
    localparam int unsigned StepW   = 9;
    localparam int unsigned AgeW    = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 11;
    localparam int unsigned SumW    = 14;

    localparam logic [PwmW-1:0]  NeutralPwm = 11'd1500;
    localparam logic [PwmW-1:0]  PwmMin     = 11'd1000;
    localparam logic [PwmW-1:0]  PwmMax     = 11'd2000;
    localparam logic [StepW-1:0] StepMin    = 9'd25;
    localparam logic [StepW-1:0] StepMax    = 9'd450;
    localparam logic [StepW-1:0] StepDelta  = 9'd25;
    localparam logic [StepW-1:0] StepReset  = 9'd50;
    localparam logic [StepW-1:0] TurnMax    = 9'd500;
    localparam logic [AgeW-1:0]  AgeMax     = 8'd255;

    localparam logic [PwmW-1:0]  CruisePwmReset = 11'd1580;
    localparam logic [AgeW-1:0]  TimeoutReset   = 8'd4;
    localparam logic [StepW-1:0] TurnReset      = 9'd150;

    typedef enum logic [1:0] {
        ACT_COMMAND = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_STATUS  = 2'd2,
        ACT_UNUSED  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CMD_FWD        = 3'd0,
        CMD_REV        = 3'd1,
        CMD_LEFT       = 3'd2,
        CMD_RIGHT      = 3'd3,
        CMD_SPEED_UP   = 3'd4,
        CMD_SPEED_DOWN = 3'd5,
        CMD_CRUISE     = 3'd6,
        CMD_BRAKE      = 3'd7
    } t_cmd;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CRUISE_PWM    = 2'd0,
        REG_TIMEOUT_TICKS = 2'd1,
        REG_TURN_OFFSET   = 2'd2,
        REG_NONE          = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PwmW-1:0]  cruise_pwm;
        logic [AgeW-1:0]  timeout_ticks;
        logic [StepW-1:0] turn_offset;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] command_code;
        logic       link_connected;
        logic       link_armed;
    } t_item;

    typedef struct packed {
        logic [PwmW-1:0] left_motor_pwm;
        logic [PwmW-1:0] right_motor_pwm;
        logic            cruise_on;
    } t_result;

    typedef struct packed {
        logic [PwmW-1:0]  throttle_pwm;
        logic [PwmW-1:0]  steering_pwm;
        logic [StepW-1:0] speed_step;
        logic             cruise_active;
        logic             connected_flag;
        logic             armed_flag;
        logic [AgeW-1:0]  throttle_age;
        logic [AgeW-1:0]  steering_age;
    } t_state;

endpackage

[rtl/core/ddtm_item_if.sv]
// ddtm_item_if: valid/ready channel carrying one input item of the mixer
// no dependencies; the field widths are written out as literals
interface ddtm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] command_code;
    logic       link_connected;
    logic       link_armed;

    modport source (output valid, action, command_code, link_connected, link_armed,
                    input ready);
    modport sink   (input valid, action, command_code, link_connected, link_armed,
                    output ready);
endinterface

[rtl/core/ddtm_result_if.sv]
// ddtm_result_if: valid/ready channel carrying one result item of the mixer
// depends on ddtm_pkg for field widths
interface ddtm_result_if;
    logic                       valid;
    logic                       ready;
    logic [ddtm_pkg::PwmW-1:0]  left_motor_pwm;
    logic [ddtm_pkg::PwmW-1:0]  right_motor_pwm;
    logic                       cruise_on;

    modport source (output valid, left_motor_pwm, right_motor_pwm, cruise_on,
                    input ready);
    modport sink   (input valid, left_motor_pwm, right_motor_pwm, cruise_on,
                    output ready);
endinterface

[rtl/core/ddtm_mixer.sv]
// ddtm_mixer: next cart state and optional result for one item, pure logic
// depends on ddtm_pkg for the state, item, config and result types
module ddtm_mixer (
    input  ddtm_pkg::t_state  i_state,
    input  ddtm_pkg::t_cfg    i_cfg,
    input  ddtm_pkg::t_item   i_item,
    output ddtm_pkg::t_state  o_state,
    output logic              o_res_valid,
    output ddtm_pkg::t_result o_res
);
    import ddtm_pkg::*;

    logic [StepW-1:0]       turn;
    logic [StepW:0]         step_up;
    logic [PwmW-1:0]        lin;
    logic signed [SumW-1:0] off;
    logic signed [SumW-1:0] sum_l;
    logic signed [SumW-1:0] sum_r;
    logic [PwmW-1:0]        left_pwm;
    logic [PwmW-1:0]        right_pwm;
    t_state                 st;

    // clamp the turn offset and precompute the raised speed step
    assign turn    = (i_cfg.turn_offset > TurnMax) ? TurnMax : i_cfg.turn_offset;
    assign step_up = {1'b0, i_state.speed_step} + {1'b0, StepDelta};

    // motor mix on the state after timeouts
    assign lin   = st.cruise_active ? i_cfg.cruise_pwm : st.throttle_pwm;
    assign off   = $signed({{(SumW-PwmW){1'b0}}, st.steering_pwm})
                 - $signed({{(SumW-PwmW){1'b0}}, NeutralPwm});
    assign sum_l = $signed({{(SumW-PwmW){1'b0}}, lin}) + off;
    assign sum_r = $signed({{(SumW-PwmW){1'b0}}, lin}) - off;

    always_comb begin
        if (sum_l < $signed({{(SumW-PwmW){1'b0}}, PwmMin})) begin
            left_pwm = PwmMin;
        end else if (sum_l > $signed({{(SumW-PwmW){1'b0}}, PwmMax})) begin
            left_pwm = PwmMax;
        end else begin
            left_pwm = sum_l[PwmW-1:0];
        end
        if (sum_r < $signed({{(SumW-PwmW){1'b0}}, PwmMin})) begin
            right_pwm = PwmMin;
        end else if (sum_r > $signed({{(SumW-PwmW){1'b0}}, PwmMax})) begin
            right_pwm = PwmMax;
        end else begin
            right_pwm = sum_r[PwmW-1:0];
        end
    end

    // state update per action
    always_comb begin
        st          = i_state;
        o_res_valid = 1'b0;
        unique case (t_action'(i_item.action))
            ACT_COMMAND: begin
                unique case (t_cmd'(i_item.command_code))
                    CMD_FWD: begin
                        st.cruise_active = 1'b0;
                        st.throttle_pwm  = NeutralPwm + {2'b0, i_state.speed_step};
                        st.throttle_age  = '0;
                    end
                    CMD_REV: begin
                        st.cruise_active = 1'b0;
                        st.throttle_pwm  = NeutralPwm - {2'b0, i_state.speed_step};
                        st.throttle_age  = '0;
                    end
                    CMD_LEFT: begin
                        st.steering_pwm = NeutralPwm - {2'b0, turn};
                        st.steering_age = '0;
                    end
                    CMD_RIGHT: begin
                        st.steering_pwm = NeutralPwm + {2'b0, turn};
                        st.steering_age = '0;
                    end
                    CMD_SPEED_UP: begin
                        st.speed_step = (step_up > {1'b0, StepMax}) ? StepMax
                                                                    : step_up[StepW-1:0];
                    end
                    CMD_SPEED_DOWN: begin
                        st.speed_step = (i_state.speed_step < StepMin + StepDelta)
                                      ? StepMin : i_state.speed_step - StepDelta;
                    end
                    CMD_CRUISE: begin
                        st.cruise_active = ~i_state.cruise_active;
                        st.throttle_pwm  = NeutralPwm;
                        st.steering_pwm  = NeutralPwm;
                    end
                    CMD_BRAKE: begin
                        st.cruise_active = 1'b0;
                        st.throttle_pwm  = NeutralPwm;
                        st.steering_pwm  = NeutralPwm;
                    end
                    default: begin
                        st = i_state;
                    end
                endcase
            end
            ACT_TICK: begin
                // ages count on every tick, link up or not
                st.steering_age = (i_state.steering_age == AgeMax) ? AgeMax
                                : i_state.steering_age + 8'd1;
                st.throttle_age = (i_state.throttle_age == AgeMax) ? AgeMax
                                : i_state.throttle_age + 8'd1;
                if (i_state.connected_flag) begin
                    o_res_valid = 1'b1;
                    if (i_state.steering_age >= i_cfg.timeout_ticks) begin
                        st.steering_pwm = NeutralPwm;
                    end
                    if (!i_state.cruise_active
                        && i_state.throttle_age >= i_cfg.timeout_ticks) begin
                        st.throttle_pwm = NeutralPwm;
                    end
                    if (!i_state.armed_flag) begin
                        st.throttle_pwm  = NeutralPwm;
                        st.steering_pwm  = NeutralPwm;
                        st.cruise_active = 1'b0;
                    end
                end
            end
            ACT_STATUS: begin
                st.connected_flag = i_item.link_connected;
                st.armed_flag     = i_item.link_armed;
            end
            ACT_UNUSED: begin
                st = i_state;
            end
            default: begin
                st = i_state;
            end
        endcase
    end

    // disarmed ticks report neutral
    assign o_state               = st;
    assign o_res.left_motor_pwm  = i_state.armed_flag ? left_pwm : NeutralPwm;
    assign o_res.right_motor_pwm = i_state.armed_flag ? right_pwm : NeutralPwm;
    assign o_res.cruise_on       = st.cruise_active;

endmodule

[rtl/core/diff_drive_teleop_mixer_core.sv]
// diff_drive_teleop_mixer_core: teleop mixer for a two-motor cart, top level
// depends on ddtm_pkg, ddtm_item_if, ddtm_result_if and ddtm_mixer
//
//  channel   dir  payload                                        handshake
//  i_item    in   action, command_code, link_connected, armed    valid/ready
//  o_result  out  left_motor_pwm, right_motor_pwm, cruise_on     valid/ready
//  cfg       in   i_cfg_idx, i_cfg_data                          i_cfg_we
//
// one item per cycle while the result register is free or read out; a tick's result
// passes the input register, then the result register; the cart state updates as the
// item leaves the input register so the next item sees it at once
// synchronous reset restores the cart state, the registers and empties both stages
// a result waiting in the output register stalls the input register's item and the input
module diff_drive_teleop_mixer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ddtm_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [ddtm_pkg::CfgW-1:0]    i_cfg_data,
    ddtm_item_if.sink                    i_item,
    ddtm_result_if.source                o_result
);
    import ddtm_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    n_out_valid;
    logic    s_go;

    // stage advance: input item moves on when the result register is free or being read out
    assign s_go         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || s_go;

    ddtm_mixer u_mixer (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res_valid (n_out_valid),
        .o_res       (n_out)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_pwm    <= CruisePwmReset;
            r_cfg.timeout_ticks <= TimeoutReset;
            r_cfg.turn_offset   <= TurnReset;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CRUISE_PWM:    r_cfg.cruise_pwm    <= i_cfg_data[PwmW-1:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[AgeW-1:0];
                REG_TURN_OFFSET:   r_cfg.turn_offset   <= i_cfg_data[StepW-1:0];
                REG_NONE:          r_cfg               <= r_cfg;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.action         <= i_item.action;
            r_in.command_code   <= i_item.command_code;
            r_in.link_connected <= i_item.link_connected;
            r_in.link_armed     <= i_item.link_armed;
        end
    end

    // cart state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.throttle_pwm   <= NeutralPwm;
            r_state.steering_pwm   <= NeutralPwm;
            r_state.speed_step     <= StepReset;
            r_state.cruise_active  <= 1'b0;
            r_state.connected_flag <= 1'b0;
            r_state.armed_flag     <= 1'b0;
            r_state.throttle_age   <= '0;
            r_state.steering_age   <= '0;
        end else if (s_go) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go) begin
            r_out_valid <= n_out_valid;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.left_motor_pwm  = r_out.left_motor_pwm;
    assign o_result.right_motor_pwm = r_out.right_motor_pwm;
    assign o_result.cruise_on       = r_out.cruise_on;

endmodule

[rtl/core/ddtm_checker.sv]
// ddtm_checker: port-level checks on the mixer top level, attached by bind
// depends on ddtm_pkg for pwm limits and on the top level's interface ports
module ddtm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ddtm_pkg::PwmW-1:0]   i_left,
    input logic [ddtm_pkg::PwmW-1:0]   i_right,
    input logic                        i_cruise
);
    import ddtm_pkg::*;

    // results are always within the motor pulse range
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left >= PwmMin) && (i_left <= PwmMax)
                     && (i_right >= PwmMin) && (i_right <= PwmMax))
        else $error("motor pwm out of range");

    // input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left)
                                        && $stable(i_right) && $stable(i_cruise))
        else $error("stalled result changed");

endmodule

bind diff_drive_teleop_mixer_core ddtm_checker u_ddtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_left      (o_result.left_motor_pwm),
    .i_right     (o_result.right_motor_pwm),
    .i_cruise    (o_result.cruise_on)
);
